@@ rtl/multi_width_crc_check_unit_assert.svh @@
// Assertion macros for the multi-width CRC check unit.
// Used by the top level; no other dependencies.
`ifndef MULTI_WIDTH_CRC_CHECK_UNIT_ASSERT_SVH
`define MULTI_WIDTH_CRC_CHECK_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication under clk, disabled in reset.
`define MWCRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication under clk, disabled in reset.
`define MWCRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MWCRC_ASSERT_NOW(lbl, ante, cons, msg)
`define MWCRC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/mwcrc_pkg.sv @@
// Package for the multi-width CRC check unit: width codes, polynomials,
// item and status types, and the byte fold function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mwcrc_pkg;

  // Width select codes
  localparam logic [1:0] WIDTH_CRC8  = 2'd0;
  localparam logic [1:0] WIDTH_CRC16 = 2'd1;
  localparam logic [1:0] WIDTH_CRC32 = 2'd2;
  localparam logic [1:0] WIDTH_CRC64 = 2'd3;
  localparam logic [1:0] WIDTH_RESET = WIDTH_CRC32;

  // Generator polynomials (implicit top bit dropped)
  localparam logic [7:0]  POLY_CRC8  = 8'h07;
  localparam logic [15:0] POLY_CRC16 = 16'h8005;
  localparam logic [31:0] POLY_CRC32 = 32'h04C11DB7;
  localparam logic [63:0] POLY_CRC64 = 64'h3A7FF201D298EE14;

  // One input item as held in the input register
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        last_byte;
    logic [63:0] expected_crc;
  } mwcrc_item_t;

  // Status exported by the core
  typedef struct packed {
    logic [1:0] width_code;
    logic       out_valid;
  } mwcrc_status_t;

  // The CRC register is kept left-aligned in 64 bits: the active width sits
  // in the top bits and the bits below it stay zero.
  function automatic logic [63:0] mwcrc_poly_top(input logic [1:0] code);
    case (code)
      WIDTH_CRC8:  return {POLY_CRC8, 56'h0};
      WIDTH_CRC16: return {POLY_CRC16, 48'h0};
      WIDTH_CRC32: return {POLY_CRC32, 32'h0};
      default:     return POLY_CRC64;
    endcase
  endfunction

  function automatic logic [63:0] mwcrc_init_top(input logic [1:0] code);
    case (code)
      WIDTH_CRC8:  return {8'hFF, 56'h0};
      WIDTH_CRC16: return {16'hFFFF, 48'h0};
      WIDTH_CRC32: return {32'hFFFF_FFFF, 32'h0};
      default:     return {64{1'b1}};
    endcase
  endfunction

  // Left-aligned CRC to zero-extended value
  function automatic logic [63:0] mwcrc_right_align(input logic [63:0] crc_top,
                                                    input logic [1:0]  code);
    case (code)
      WIDTH_CRC8:  return {56'h0, crc_top[63:56]};
      WIDTH_CRC16: return {48'h0, crc_top[63:48]};
      WIDTH_CRC32: return {32'h0, crc_top[63:32]};
      default:     return crc_top;
    endcase
  endfunction

  function automatic logic [63:0] mwcrc_mask(input logic [1:0] code);
    case (code)
      WIDTH_CRC8:  return {56'h0, 8'hFF};
      WIDTH_CRC16: return {48'h0, 16'hFFFF};
      WIDTH_CRC32: return {32'h0, 32'hFFFF_FFFF};
      default:     return {64{1'b1}};
    endcase
  endfunction

  // Byte into the top byte, then eight MSB-first shift steps
  function automatic logic [63:0] mwcrc_fold_byte(input logic [63:0] crc_top,
                                                  input logic [7:0]  data,
                                                  input logic [63:0] poly_top);
    logic [63:0] c;
    c = crc_top ^ {data, 56'h0};
    for (int i = 0; i < 8; i++) begin
      c = c[63] ? ((c << 1) ^ poly_top) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/mwcrc_in_reg.sv @@
// Input register of the multi-width CRC check unit: captures one item per
// transfer and holds it until the core takes it. Depends on mwcrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mwcrc_in_reg
  import mwcrc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire mwcrc_item_t in_item,
  output logic             hold_valid,
  output mwcrc_item_t      hold_item,
  input  wire logic        hold_take
);

  logic        hold_valid_r, hold_valid_nxt;
  mwcrc_item_t hold_item_r;
  logic        load;

  // Stall only while a held item cannot move on this cycle
  assign in_stall = hold_valid_r && !hold_take;
  assign load     = in_valid && !in_stall;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (load) begin
      hold_valid_nxt = 1'b1;
    end else if (hold_take) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      hold_item_r <= in_item;
    end
  end

  assign hold_valid = hold_valid_r;
  assign hold_item  = hold_item_r;

endmodule

`default_nettype wire

@@ rtl/mwcrc_core.sv @@
// CRC core: width register, running CRC, combinational byte fold, compare
// and result register. Depends on mwcrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mwcrc_core
  import mwcrc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  input  wire logic [1:0]  cfg_data,
  input  wire logic        hold_valid,
  input  wire mwcrc_item_t hold_item,
  output logic             hold_take,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_crc_value,
  output logic             out_crc_match,
  output mwcrc_status_t    status
);

  logic [1:0]  width_r;
  logic [63:0] crc_r, crc_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] crc_value_r;
  logic        crc_match_r;
  logic [63:0] folded;
  logic [63:0] result;
  logic        out_free;

  // A result slot is free when empty or being drained this cycle
  assign out_free  = !out_valid_r || !out_stall;
  assign hold_take = hold_valid && (!hold_item.last_byte || out_free);

  // Fold the held byte into the running CRC
  assign folded = hold_item.has_byte
                ? mwcrc_fold_byte(crc_r, hold_item.data_byte, mwcrc_poly_top(width_r))
                : crc_r;
  assign result = mwcrc_right_align(folded, width_r);

  always_comb begin
    crc_nxt = crc_r;
    if (cfg_valid) begin
      crc_nxt = mwcrc_init_top(cfg_data);
    end else if (hold_take) begin
      crc_nxt = hold_item.last_byte ? mwcrc_init_top(width_r) : folded;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (hold_take && hold_item.last_byte) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= WIDTH_RESET;
      crc_r       <= mwcrc_init_top(WIDTH_RESET);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        width_r <= cfg_data;
      end
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, loaded when a message ends
  always_ff @(posedge clk) begin
    if (hold_take && hold_item.last_byte) begin
      crc_value_r <= result;
      crc_match_r <= (result == (hold_item.expected_crc & mwcrc_mask(width_r)));
    end
  end

  assign out_valid         = out_valid_r;
  assign out_crc_value     = crc_value_r;
  assign out_crc_match     = crc_match_r;
  assign status.width_code = width_r;
  assign status.out_valid  = out_valid_r;

endmodule

`default_nettype wire

@@ rtl/multi_width_crc_check_unit.sv @@
// Top level of the multi-width CRC check unit: input register plus CRC core.
// Depends on mwcrc_pkg, mwcrc_in_reg, mwcrc_core and the assertion header.
//
// Byte-serial MSB-first CRC of 8, 16, 32 or 64 bits (width_code 0..3, reset
// 32 bits), initial value all ones, no final XOR. One item is accepted per
// cycle while no last item waits on a blocked result slot; an item is held in
// the input register and its result, if last_byte is set, is loaded into the
// output register when the core takes it, which raises out_valid. The rate of
// one byte per cycle is set by the loop through the eight-step fold and the
// CRC register. Writing cfg_data reloads the initial value of the new width;
// cfg_ready is always high and writes are meant for idle periods.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_width_crc_check_unit_assert.svh"

module multi_width_crc_check_unit
  import mwcrc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_width_code,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_has_byte,
  input  wire logic        in_last_byte,
  input  wire logic [63:0] in_expected_crc,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_crc_value,
  output logic             out_crc_match
);

  mwcrc_item_t   in_item;
  mwcrc_item_t   hold_item;
  logic          hold_valid;
  logic          hold_take;
  mwcrc_status_t status;

  assign cfg_ready = 1'b1;

  assign in_item.data_byte    = in_data_byte;
  assign in_item.has_byte     = in_has_byte;
  assign in_item.last_byte    = in_last_byte;
  assign in_item.expected_crc = in_expected_crc;

  mwcrc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .hold_valid (hold_valid),
    .hold_item  (hold_item),
    .hold_take  (hold_take)
  );

  mwcrc_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid && cfg_ready),
    .cfg_data      (cfg_width_code),
    .hold_valid    (hold_valid),
    .hold_item     (hold_item),
    .hold_take     (hold_take),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_crc_value (out_crc_value),
    .out_crc_match (out_crc_match),
    .status        (status)
  );

  // Input stalls only behind a last item waiting on a blocked result slot
  `MWCRC_ASSERT_NOW(a_stall_cause, in_stall, hold_valid && hold_item.last_byte && out_valid && out_stall, "input stalled without a blocked result")
  // A new result follows a held last item taken in the previous cycle
  `MWCRC_ASSERT_NEXT(a_result_source, hold_take && hold_item.last_byte, out_valid, "result lost after message end")
  // Result bits above the selected width are zero
  `MWCRC_ASSERT_NOW(a_crc8_range, status.out_valid && status.width_code == WIDTH_CRC8, out_crc_value[63:8] == 56'h0, "CRC-8 result wider than 8 bits")
  `MWCRC_ASSERT_NOW(a_crc16_range, status.out_valid && status.width_code == WIDTH_CRC16, out_crc_value[63:16] == 48'h0, "CRC-16 result wider than 16 bits")

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for multi_width_crc_check_unit. It drives random messages
// at every CRC width through the stall handshakes and checks each CRC result.
// Depends on mwcrc_pkg and the unit's RTL only.

module testbench;
  import mwcrc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASE_ITEMS    = 180;
  localparam int NUM_PHASES     = 8;
  // Width per phase, phase 0 in the low bits
  localparam logic [15:0] WIDTH_PLAN = {WIDTH_CRC32, WIDTH_CRC16, WIDTH_CRC8, WIDTH_CRC64,
                                        WIDTH_CRC32, WIDTH_CRC64, WIDTH_CRC16, WIDTH_CRC8};

  typedef struct packed {
    logic [63:0] crc_value;
    logic        crc_match;
  } crc_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_width_code = WIDTH_RESET;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_has_byte = 1'b0;
  logic        in_last_byte = 1'b0;
  logic [63:0] in_expected_crc = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_crc_value;
  logic        out_crc_match;

  mwcrc_item_t pending_items[$];
  crc_result_t expected_results[$];
  mwcrc_item_t drv_item;
  int          items_unsent = 0;
  int          message_items = 0;

  // Shadow of the unit's width register and running CRC
  logic [1:0]  model_width = WIDTH_RESET;
  logic [63:0] model_crc = 64'hFFFF_FFFF;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  multi_width_crc_check_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_width_code  (cfg_width_code),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_has_byte     (in_has_byte),
    .in_last_byte    (in_last_byte),
    .in_expected_crc (in_expected_crc),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_crc_value   (out_crc_value),
    .out_crc_match   (out_crc_match)
  );

  function automatic logic [63:0] width_mask(input logic [1:0] code);
    case (code)
      WIDTH_CRC8:  return 64'hFF;
      WIDTH_CRC16: return 64'hFFFF;
      WIDTH_CRC32: return 64'hFFFF_FFFF;
      default:     return {64{1'b1}};
    endcase
  endfunction

  // Right-aligned CRC: byte into the top byte of the width, eight MSB-first steps
  function automatic logic [63:0] crc_fold_byte(input logic [63:0] crc, input logic [7:0] data,
                                                input logic [1:0] code);
    logic [63:0] mask;
    logic [63:0] poly;
    int          nbits;
    mask = width_mask(code);
    case (code)
      WIDTH_CRC8: begin
        nbits = 8;
        poly  = {56'h0, POLY_CRC8};
      end
      WIDTH_CRC16: begin
        nbits = 16;
        poly  = {48'h0, POLY_CRC16};
      end
      WIDTH_CRC32: begin
        nbits = 32;
        poly  = {32'h0, POLY_CRC32};
      end
      default: begin
        nbits = 64;
        poly  = POLY_CRC64;
      end
    endcase
    crc = (crc & mask) ^ ({56'h0, data} << (nbits - 8));
    for (int i = 0; i < 8; i++) begin
      if (crc[nbits - 1]) crc = ((crc << 1) ^ poly) & mask;
      else crc = (crc << 1) & mask;
    end
    return crc;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Update the shadow CRC for one accepted transfer and queue any result
  task automatic predict_crc(input mwcrc_item_t item);
    logic [63:0] mask;
    crc_result_t res;
    mask = width_mask(model_width);
    if (item.has_byte) model_crc = crc_fold_byte(model_crc, item.data_byte, model_width);
    if (item.last_byte) begin
      res.crc_value = model_crc & mask;
      res.crc_match = (res.crc_value == (item.expected_crc & mask));
      expected_results.push_back(res);
      model_crc = mask;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: mismatch on %s, got %h, expected %h", $time, what, got, want);
    error_count++;
  endtask

  task automatic push_item(input logic [7:0] data, input logic has, input logic last,
                           input logic [63:0] expv);
    mwcrc_item_t item;
    item.data_byte    = data;
    item.has_byte     = has;
    item.last_byte    = last;
    item.expected_crc = expv;
    pending_items.push_back(item);
    items_unsent++;
    if (has || last) message_items++;
  endtask

  // One message with random bytes; closed messages end with a result
  task automatic add_message(input logic [1:0] code, input int len, input bit closed);
    logic [63:0] mask;
    logic [63:0] crc;
    logic [63:0] expv;
    logic [7:0]  data;
    bit          separate_tail;
    mask = width_mask(code);
    crc = mask;
    separate_tail = (len == 0) || ($urandom_range(1) == 1);
    for (int i = 0; i < len; i++) begin
      // noise: no byte, no end mark
      if ($urandom_range(9) == 0) push_item(8'($urandom), 1'b0, 1'b0, rand64());
      case ($urandom_range(7))
        0:       data = 8'h00;
        1:       data = 8'hFF;
        default: data = 8'($urandom);
      endcase
      crc = crc_fold_byte(crc, data, code);
      case ($urandom_range(3))
        0, 1:    expv = (rand64() & ~mask) | crc;
        2:       expv = crc ^ (64'h1 << $urandom_range(63));
        default: expv = rand64();
      endcase
      push_item(data, 1'b1, closed && !separate_tail && (i == len - 1), expv);
    end
    if (closed && separate_tail) begin
      expv = ($urandom_range(1) == 1) ? ((rand64() & ~mask) | crc) : rand64();
      push_item(8'($urandom), 1'b0, 1'b1, expv);
    end
  endtask

  // Sender pauses until every transfer is done and every result is back
  task automatic wait_idle();
    while (items_unsent > 0 || expected_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_width(input logic [1:0] code);
    cfg_valid <= 1'b1;
    cfg_width_code <= code;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    model_width = code;
    model_crc = width_mask(code);
  endtask

  function automatic int message_len();
    return ($urandom_range(3) == 0) ? $urandom_range(40) : $urandom_range(8);
  endfunction

  // Input driver: holds a stalled transfer, otherwise loads the next pending item
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_crc(drv_item);
        items_unsent--;
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_item = pending_items.pop_front();
          in_valid        <= 1'b1;
          in_data_byte    <= drv_item.data_byte;
          in_has_byte     <= drv_item.has_byte;
          in_last_byte    <= drv_item.last_byte;
          in_expected_crc <= drv_item.expected_crc;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall
  always @(posedge clk) begin : result_monitor
    crc_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", out_crc_value, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_crc_value !== want.crc_value)
          report_mismatch("crc_value", out_crc_value, want.crc_value);
        if (out_crc_match !== want.crc_match)
          report_mismatch("crc_match", {63'h0, out_crc_match}, {63'h0, want.crc_match});
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus sequence
  initial begin
    logic [1:0] code;
    int         phase_start;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed messages at the reset width (CRC-32)
    push_item(8'h00, 1'b0, 1'b1, 64'hFFFF_FFFF);           // empty message, match
    push_item(8'hA5, 1'b0, 1'b1, 64'h0);                   // empty message, no match
    push_item(8'h3C, 1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF); // no byte, no end: ignored
    for (int i = 0; i < 9; i++)                            // "123456789", upper bits set
      push_item(8'h31 + 8'(i), 1'b1, i == 8, 64'hFFFF_FFFF_0376_E6E7);
    push_item(8'hFF, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF); // byte and end together
    push_item(8'h00, 1'b1, 1'b0, 64'h0);
    push_item(8'h80, 1'b1, 1'b0, 64'h0);
    push_item(8'h00, 1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF); // end mark after bytes
    push_item(8'h01, 1'b1, 1'b1, 64'h0);
    push_item(8'h7F, 1'b1, 1'b0, rand64());                // left open, dropped by write
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      code = WIDTH_PLAN[2*p +: 2];
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 47;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 47;
        end
        default: begin
          send_idle_pct = 34;
          recv_stall_pct = 34;
        end
      endcase
      write_width(code);
      phase_start = message_items;
      while (message_items - phase_start < PHASE_ITEMS / 2) add_message(code, message_len(), 1'b1);
      wait_idle();
      while (message_items - phase_start < PHASE_ITEMS) add_message(code, message_len(), 1'b1);
      // sometimes leave a partial message for the next width write to discard
      if ($urandom_range(1) == 1) add_message(code, $urandom_range(1, 5), 1'b0);
      wait_idle();
    end

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
